### rtl/stack_bytecode_interpreter_macros.svh
// ----------------------------------------------------------------------------
// stack bytecode interpreter assertion macros
// shared property wrappers, sampled on clk with reset held off
// ----------------------------------------------------------------------------
`ifndef STACK_BYTECODE_INTERPRETER_MACROS_SVH
`define STACK_BYTECODE_INTERPRETER_MACROS_SVH

// same-cycle implication
`define SBI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// widths, sizes and opcodes of the stack bytecode interpreter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

	localparam int OBJ_W             = 6;
	localparam int CODE_W            = 8;
	localparam int ARG_W             = 4;
	localparam int VALUE_W           = 32;

	localparam int STACK_DEPTH       = 16;
	localparam int FIELDS_PER_OBJECT = 8;
	localparam int OBJECT_COUNT      = 64;

	localparam int FIELD_WORDS = OBJECT_COUNT * FIELDS_PER_OBJECT;
	localparam int FIELD_AW    = $clog2(FIELD_WORDS);
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

	typedef enum logic [ARG_W-1:0] {
		OP_PUSH_FIELD  = 4'd0,
		OP_POP_FIELD   = 4'd1,
		OP_PUSH_CONST  = 4'd2,
		OP_ADD         = 4'd3,
		OP_SUB         = 4'd4,
		OP_HALT        = 4'd5
	} op_t;

endpackage

`default_nettype wire

### rtl/sbi_if.sv
// ----------------------------------------------------------------------------
// sbi channels
// valid/ready channels for bytecode beats and result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbi_cmd_if import sbi_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OBJ_W-1:0]   object_index;
	logic [CODE_W-1:0]  bytecode;
	logic               first_of_send;
	logic               last_of_method;

	modport source (output valid, object_index, bytecode, first_of_send, last_of_method,
		input ready);
	modport sink (input valid, object_index, bytecode, first_of_send, last_of_method,
		output ready);
endinterface

interface sbi_rsp_if import sbi_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] result_value;
	logic               has_value;

	modport source (output valid, result_value, has_value, input ready);
	modport sink (input valid, result_value, has_value, output ready);
endinterface

`default_nettype wire

### rtl/sbi_ram.sv
// ----------------------------------------------------------------------------
// sbi_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/stack_bytecode_interpreter.sv
// ----------------------------------------------------------------------------
// stack_bytecode_interpreter
// runs one bytecode per beat against an operand stack and object fields
// ----------------------------------------------------------------------------
//  channel | dir | payload                                            | beat
//  cmd     | in  | object_index, bytecode, first_of_send, last_method | one bytecode
//  rsp     | out | result_value, has_value                            | zero or one per bytecode
//
//  one bytecode per cycle while rsp does not stall: field ram read at accept, executed from the s1 stage
//  top two stack entries live in registers, deeper ones in a 16-entry ram
//  whose next read address follows the new depth, with write forwarding
//  after reset all 512 words of the field ram are cleared with cmd.ready low
//  a result held in rsp stalls execution; cmd keeps one beat in the stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stack_bytecode_interpreter_macros.svh"

module stack_bytecode_interpreter import sbi_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	sbi_cmd_if.sink    cmd,
	sbi_rsp_if.source  rsp
);

	// clearing pass over the field ram
	logic                clearing_q;
	logic [FIELD_AW-1:0] clr_cnt_q;

	// execute stage
	logic                s1_valid_q;
	op_t                 op_s1;
	logic [ARG_W-1:0]    arg_s1;
	logic                first_s1;
	logic                last_s1;
	logic                slot_ok_s1;
	logic [FIELD_AW-1:0] slot_s1;
	logic                fld_fwd_s1;
	logic [VALUE_W-1:0]  fld_fwd_data_s1;

	// stack state
	logic [DEPTH_W-1:0]  depth_q;
	logic                halted_q;
	logic [VALUE_W-1:0]  tos_q;
	logic [VALUE_W-1:0]  nos_q;
	logic                stk_fwd_q;
	logic [VALUE_W-1:0]  stk_fwd_data_q;

	// output register
	logic                out_valid_q;
	logic [VALUE_W-1:0]  result_value_q;
	logic                has_value_q;

	logic                cmd_fire;
	logic                s1_fire;
	logic [ARG_W-1:0]    arg_in;
	logic                slot_ok_in;
	logic [FIELD_AW-1:0] slot_in;

	logic [VALUE_W-1:0]  fld_rd_data;
	logic [VALUE_W-1:0]  stk_rd_data;
	logic                fld_we;
	logic                fld_ram_we;
	logic [FIELD_AW-1:0] fld_waddr;
	logic [VALUE_W-1:0]  fld_wdata;

	logic [DEPTH_W-1:0]  d;
	logic                halted;
	logic [VALUE_W-1:0]  third;
	logic [VALUE_W-1:0]  fld_val;
	logic [DEPTH_W-1:0]  d_n;
	logic [VALUE_W-1:0]  tos_n;
	logic [VALUE_W-1:0]  nos_n;
	logic                halted_n;
	logic                push;
	logic                pop;
	logic [VALUE_W-1:0]  push_val;
	logic                stk_we;
	logic                stk_ram_we;
	logic [STK_AW-1:0]   stk_waddr;
	logic [STK_AW-1:0]   stk_raddr;
	logic [DEPTH_W-1:0]  depth_next;
	logic                res_valid;
	logic [VALUE_W-1:0]  res_value;
	logic                res_has;

	assign s1_fire   = s1_valid_q && (!out_valid_q || rsp.ready);
	assign cmd.ready = !clearing_q && (!s1_valid_q || s1_fire);
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign arg_in     = cmd.bytecode[ARG_W-1:0];
	assign slot_ok_in = (int'(cmd.object_index) < OBJECT_COUNT)
		&& (int'(arg_in) < FIELDS_PER_OBJECT);
	assign slot_in    = slot_ok_in
		? FIELD_AW'(int'(cmd.object_index) * FIELDS_PER_OBJECT + int'(arg_in))
		: '0;

	// ------------------------------------------------------------------
	// execute
	// ------------------------------------------------------------------
	always_comb begin
		d         = first_s1 ? '0 : depth_q;
		halted    = first_s1 ? 1'b0 : halted_q;
		third     = stk_fwd_q ? stk_fwd_data_q : stk_rd_data;
		fld_val   = fld_fwd_s1 ? fld_fwd_data_s1 : fld_rd_data;
		d_n       = d;
		tos_n     = tos_q;
		nos_n     = nos_q;
		halted_n  = halted;
		push      = 1'b0;
		pop       = 1'b0;
		push_val  = '0;
		stk_we    = 1'b0;
		fld_we    = 1'b0;
		res_valid = 1'b0;
		res_value = '0;
		res_has   = 1'b0;
		if (!halted) begin
			case (op_s1)
				OP_PUSH_FIELD: begin
					if (slot_ok_s1) begin
						push     = 1'b1;
						push_val = fld_val;
					end
				end
				OP_POP_FIELD: begin
					if (slot_ok_s1 && d != '0) begin
						fld_we = 1'b1;
						pop    = 1'b1;
					end
				end
				OP_PUSH_CONST: begin
					push     = 1'b1;
					push_val = VALUE_W'(arg_s1);
				end
				OP_ADD, OP_SUB: begin
					if (d >= DEPTH_W'(2)) begin
						tos_n = (op_s1 == OP_ADD) ? nos_q + tos_q : nos_q - tos_q;
						nos_n = third;
						d_n   = d - DEPTH_W'(1);
					end
				end
				OP_HALT: begin
					halted_n  = 1'b1;
					res_valid = 1'b1;
					if (d != '0) begin
						res_value = tos_q;
						res_has   = 1'b1;
						pop       = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (push && d < DEPTH_W'(STACK_DEPTH)) begin
				// old second entry spills into the ram
				stk_we = d >= DEPTH_W'(2);
				nos_n  = tos_q;
				tos_n  = push_val;
				d_n    = d + DEPTH_W'(1);
			end
			if (pop) begin
				tos_n = nos_q;
				nos_n = third;
				d_n   = d - DEPTH_W'(1);
			end
			if (last_s1 && !res_valid) begin
				res_valid = 1'b1;
				if (d_n != '0) begin
					res_value = tos_n;
					res_has   = 1'b1;
				end
			end
		end
	end

	assign stk_ram_we = s1_fire && stk_we;
	assign stk_waddr  = STK_AW'(d - DEPTH_W'(2));
	assign depth_next = s1_fire ? d_n : depth_q;
	// prefetch the third entry for the depth after this cycle
	assign stk_raddr  = STK_AW'(depth_next - DEPTH_W'(3));

	assign fld_ram_we = clearing_q || (s1_fire && fld_we);
	assign fld_waddr  = clearing_q ? clr_cnt_q : slot_s1;
	assign fld_wdata  = clearing_q ? '0 : tos_q;

	sbi_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (FIELD_WORDS)
	) u_field_ram (
		.clk   (clk),
		.we    (fld_ram_we),
		.waddr (fld_waddr),
		.wdata (fld_wdata),
		.re    (cmd_fire),
		.raddr (slot_in),
		.rdata (fld_rd_data)
	);

	sbi_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_ram_we),
		.waddr (stk_waddr),
		.wdata (nos_q),
		.re    (1'b1),
		.raddr (stk_raddr),
		.rdata (stk_rd_data)
	);

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			s1_valid_q  <= 1'b0;
			fld_fwd_s1  <= 1'b0;
			depth_q     <= '0;
			halted_q    <= 1'b0;
			stk_fwd_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + FIELD_AW'(1);
				if (clr_cnt_q == FIELD_AW'(FIELD_WORDS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (cmd_fire) begin
				s1_valid_q <= 1'b1;
				// store in flight to the slot being read
				fld_fwd_s1 <= s1_fire && fld_we && slot_ok_in && (slot_in == slot_s1);
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				depth_q  <= d_n;
				halted_q <= halted_n;
			end
			stk_fwd_q <= stk_ram_we && (stk_waddr == stk_raddr);
			if (s1_fire && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_s1           <= op_t'(cmd.bytecode[CODE_W-1:ARG_W]);
			arg_s1          <= arg_in;
			first_s1        <= cmd.first_of_send;
			last_s1         <= cmd.last_of_method;
			slot_ok_s1      <= slot_ok_in;
			slot_s1         <= slot_in;
			fld_fwd_data_s1 <= tos_q;
		end
		if (s1_fire) begin
			tos_q <= tos_n;
			nos_q <= nos_n;
		end
		stk_fwd_data_q <= nos_q;
		if (s1_fire && res_valid) begin
			result_value_q <= res_value;
			has_value_q    <= res_has;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = result_value_q;
	assign rsp.has_value    = has_value_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`SBI_ASSERT_IMP(a_no_cmd_while_clearing, clearing_q, !cmd.ready,
		"bytecode accepted during field clear")
	`SBI_ASSERT_NXT(a_stage_holds_on_stall, s1_valid_q && out_valid_q && !rsp.ready,
		s1_valid_q, "execute stage dropped a beat under output stall")
	`SBI_ASSERT_IMP(a_empty_result_zero, out_valid_q && !has_value_q, result_value_q == '0,
		"empty-stack result carries a nonzero value")
	`SBI_ASSERT_IMP(a_depth_bound, s1_valid_q, depth_q <= DEPTH_W'(STACK_DEPTH),
		"stack depth beyond capacity")

endmodule

`default_nettype wire
